// File: design/glet_pkg.sv
package glet_pkg;

  // Frame geometry limits and the widths that follow from them.
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // Register and field widths.
  localparam int PIX_W     = 8;
  localparam int FW_W      = 12;
  localparam int FH_W      = 13;
  localparam int THR_W     = 11;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int LAP_W     = 12;

  localparam logic [FW_W-1:0]         FW_RST  = 12'd640;
  localparam logic [FH_W-1:0]         FH_RST  = 13'd480;
  localparam logic signed [THR_W-1:0] THR_RST = 11'sd25;

  // Fixed-point luma weights, scaled by 256.
  localparam int GRAY_WR = 77;
  localparam int GRAY_WG = 150;
  localparam int GRAY_WB = 29;

  // Result queue.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_THRESH = 2'd2
  } cfg_idx_e;

  // Per-item decode that travels with an item down the pipeline.
  typedef struct packed {
    logic drain;
    logic emit;
    logic has_a;
    logic left_a_mid;
    logic has_b;
    logic left_b_mid;
    logic up_mid;
  } item_ctl_t;

  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } column_t;

  typedef struct packed {
    logic edge_res;
    logic row_end;
    logic frame_end;
    logic last_in_run;
  } result_t;

endpackage

// File: design/glet_ctrl.sv
module glet_ctrl
  import glet_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_wdata_i,
  input  logic                    accept_i,
  input  logic                    kind_i,
  input  logic [PIX_W-1:0]        red_i,
  input  logic [PIX_W-1:0]        green_i,
  input  logic [PIX_W-1:0]        blue_i,
  output logic [COL_W-1:0]        addr_o,
  output logic                    wr_o,
  output logic [PIX_W-1:0]        gray_o,
  output item_ctl_t               ctl_o,
  output logic signed [THR_W-1:0] thr_o
);

  logic [FW_W-1:0]         fw_q;
  logic [FH_W-1:0]         fh_q;
  logic signed [THR_W-1:0] thr_q;

  logic [COL_W-1:0] col_q, col_d;
  logic [COL_W-1:0] drain_q, drain_d;
  logic [ROW_W-1:0] row_q, row_d;

  logic [COL_W-1:0]   wm1;
  logic [ROW_W-1:0]   hm1;
  logic [COL_W-1:0]   cur;
  logic               row_last;
  logic [2*PIX_W-1:0] gsum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= FW_RST;
      fh_q  <= FH_RST;
      thr_q <= THR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:  fw_q  <= cfg_wdata_i[FW_W-1:0];
        CFG_HEIGHT: fh_q  <= cfg_wdata_i[FH_W-1:0];
        CFG_THRESH: thr_q <= $signed(cfg_wdata_i[THR_W-1:0]);
        default: ;
      endcase
    end
  end

  // Effective width and height minus one, clamped to the supported range.
  always_comb begin
    if (fw_q == '0) begin
      wm1 = '0;
    end else if (int'(fw_q) > MAX_WIDTH) begin
      wm1 = COL_W'(MAX_WIDTH - 1);
    end else begin
      wm1 = COL_W'(fw_q - FW_W'(1));
    end
    if (fh_q == '0) begin
      hm1 = '0;
    end else if (int'(fh_q) > MAX_HEIGHT) begin
      hm1 = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      hm1 = ROW_W'(fh_q - FH_W'(1));
    end
  end

  assign gsum = ({8'd0, red_i}   * 16'(GRAY_WR))
              + ({8'd0, green_i} * 16'(GRAY_WG))
              + ({8'd0, blue_i}  * 16'(GRAY_WB));

  always_comb begin
    cur      = kind_i ? drain_q : col_q;
    row_last = (cur >= wm1);

    ctl_o.drain      = kind_i;
    ctl_o.emit       = kind_i || (row_q != '0);
    ctl_o.has_a      = (cur != '0);
    ctl_o.left_a_mid = (cur == COL_W'(1));
    ctl_o.has_b      = row_last;
    ctl_o.left_b_mid = (cur != '0);
    ctl_o.up_mid     = kind_i ? (hm1 == '0) : (row_q == ROW_W'(1));

    col_d   = col_q;
    row_d   = row_q;
    drain_d = drain_q;
    if (accept_i) begin
      if (kind_i) begin
        drain_d = row_last ? '0 : COL_W'(cur + COL_W'(1));
      end else if (row_last) begin
        col_d = '0;
        row_d = (row_q >= hm1) ? '0 : ROW_W'(row_q + ROW_W'(1));
      end else begin
        col_d = COL_W'(cur + COL_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      drain_q <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      drain_q <= drain_d;
    end
  end

  assign addr_o = cur;
  assign wr_o   = !kind_i;
  assign gray_o = gsum[2*PIX_W-1:PIX_W];
  assign thr_o  = thr_q;

endmodule

// File: design/glet_line_mem.sv
module glet_line_mem
  import glet_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [COL_W-1:0] addr_i,
  input  logic             wr_i,
  input  logic [PIX_W-1:0] gray_i,
  output logic             col_valid_o,
  output column_t          col_o
);

  logic [PIX_W-1:0] mem_up  [MAX_WIDTH];
  logic [PIX_W-1:0] mem_mid [MAX_WIDTH];

  logic [PIX_W-1:0] up_rd_q, mid_rd_q;
  logic [PIX_W-1:0] fwd_up_q, fwd_mid_q;
  logic             fwd_q;
  logic             valid_q;
  logic             wr_q;
  logic [COL_W-1:0] addr_q;
  logic [PIX_W-1:0] gray_q;

  logic             we;
  logic [PIX_W-1:0] up_cur, mid_cur;

  // An item that reads the entry written in the same cycle takes the
  // written values from the bypass registers.
  assign up_cur  = fwd_q ? fwd_up_q  : up_rd_q;
  assign mid_cur = fwd_q ? fwd_mid_q : mid_rd_q;
  assign we      = valid_q && wr_q;

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      up_rd_q  <= mem_up[addr_i];
      mid_rd_q <= mem_mid[addr_i];
    end
    if (we) begin
      mem_up[addr_q]  <= mid_cur;
      mem_mid[addr_q] <= gray_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      addr_q    <= addr_i;
      wr_q      <= wr_i;
      gray_q    <= gray_i;
      fwd_up_q  <= mid_cur;
      fwd_mid_q <= gray_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      fwd_q   <= 1'b0;
    end else begin
      valid_q <= rd_en_i;
      if (rd_en_i) begin
        fwd_q <= we && (addr_q == addr_i);
      end
    end
  end

  assign col_valid_o = valid_q;
  assign col_o.top   = up_cur;
  assign col_o.mid   = mid_cur;
  assign col_o.bot   = wr_q ? gray_q : mid_cur;

endmodule

// File: design/glet_window.sv
module glet_window
  import glet_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  item_ctl_t               ctl_i,
  input  logic                    col_valid_i,
  input  column_t                 col_i,
  input  logic signed [THR_W-1:0] thr_i,
  output logic                    s2_valid_o,
  output logic                    push_a_o,
  output result_t                 res_a_o,
  output logic                    push_b_o,
  output result_t                 res_b_o
);

  logic [PIX_W-1:0] win_q [3][3];
  item_ctl_t        ctl_s1_q, ctl_s2_q;
  logic             s2_valid_q;

  function automatic logic lap_exceeds(
    input logic [PIX_W-1:0]        c,
    input logic [PIX_W-1:0]        u,
    input logic [PIX_W-1:0]        d,
    input logic [PIX_W-1:0]        l,
    input logic [PIX_W-1:0]        r,
    input logic signed [THR_W-1:0] thr
  );
    logic signed [LAP_W-1:0] s;
    logic signed [LAP_W-1:0] t;
    s = $signed({2'b00, c, 2'b00}) - $signed({4'b0000, u}) - $signed({4'b0000, d})
      - $signed({4'b0000, l}) - $signed({4'b0000, r});
    t = LAP_W'(thr);
    return s > t;
  endfunction

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      ctl_s1_q <= ctl_i;
    end
    if (col_valid_i) begin
      ctl_s2_q <= ctl_s1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          win_q[r][k] <= '0;
        end
      end
    end else begin
      s2_valid_q <= col_valid_i;
      if (col_valid_i) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r][0] <= win_q[r][1];
          win_q[r][1] <= win_q[r][2];
        end
        win_q[0][2] <= col_i.top;
        win_q[1][2] <= col_i.mid;
        win_q[2][2] <= col_i.bot;
      end
    end
  end

  // The up, down and left neighbors fall back to the center row at borders.
  always_comb begin
    res_a_o.edge_res = lap_exceeds(
      win_q[1][1],
      ctl_s2_q.up_mid     ? win_q[1][1] : win_q[0][1],
      ctl_s2_q.drain      ? win_q[1][1] : win_q[2][1],
      ctl_s2_q.left_a_mid ? win_q[1][1] : win_q[1][0],
      win_q[1][2], thr_i);
    res_a_o.row_end     = 1'b0;
    res_a_o.frame_end   = 1'b0;
    res_a_o.last_in_run = !ctl_s2_q.has_b;

    res_b_o.edge_res = lap_exceeds(
      win_q[1][2],
      ctl_s2_q.up_mid     ? win_q[1][2] : win_q[0][2],
      ctl_s2_q.drain      ? win_q[1][2] : win_q[2][2],
      ctl_s2_q.left_b_mid ? win_q[1][1] : win_q[1][2],
      win_q[1][2], thr_i);
    res_b_o.row_end     = 1'b1;
    res_b_o.frame_end   = ctl_s2_q.drain;
    res_b_o.last_in_run = 1'b1;
  end

  assign s2_valid_o = s2_valid_q;
  assign push_a_o   = s2_valid_q && ctl_s2_q.emit && ctl_s2_q.has_a;
  assign push_b_o   = s2_valid_q && ctl_s2_q.emit && ctl_s2_q.has_b;

endmodule

// File: design/glet_out_fifo.sv
module glet_out_fifo
  import glet_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_a_i,
  input  result_t            res_a_i,
  input  logic               push_b_i,
  input  result_t            res_b_i,
  input  logic               pop_i,
  output logic               valid_o,
  output result_t            data_o,
  output logic [FIFO_CW-1:0] count_o
);

  result_t            mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_q, rp_q;
  logic [FIFO_CW-1:0] cnt_q, cnt_d;
  logic [FIFO_AW-1:0] wp_b;

  assign wp_b = push_a_i ? FIFO_AW'(wp_q + FIFO_AW'(1)) : wp_q;

  always_ff @(posedge clk_i) begin
    if (push_a_i) begin
      mem_q[wp_q] <= res_a_i;
    end
    if (push_b_i) begin
      mem_q[wp_b] <= res_b_i;
    end
  end

  always_comb begin
    cnt_d = FIFO_CW'(cnt_q + FIFO_CW'(push_a_i) + FIFO_CW'(push_b_i) - FIFO_CW'(pop_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= FIFO_AW'(wp_q + FIFO_AW'(push_a_i) + FIFO_AW'(push_b_i));
      rp_q  <= FIFO_AW'(rp_q + FIFO_AW'(pop_i));
      cnt_q <= cnt_d;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rp_q];
  assign count_o = cnt_q;

endmodule

// File: design/grayscale_laplacian_edge_threshold.sv
// Laplacian edge detector on an RGB raster stream, one input transfer per clock while the
//   result queue has room; results are queued after the line-store and window registers.
// The rate is set by the single read-modify-write port pair of the line stores; a
//   row-end item pushes up to two results into an eight-entry result queue.
// Reset: rst_ni returns the configuration registers to their defaults and clears the
//   counters, window and queue; line stores are not cleared.
module grayscale_laplacian_edge_threshold
  import glet_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration write port: index 0 width, 1 height, 2 threshold.
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  // Input stream.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic                 s_axis_tuser,   // kind: 0 pixel, 1 drain item
  // Result stream.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,   // edge_res[0], zero fill [7:1]
  output logic [1:0]           m_axis_tuser,   // row_end[0], frame_end[1]
  output logic                 m_axis_tlast    // last_in_run
);

  logic                    in_xfer;
  logic [COL_W-1:0]        rd_addr;
  logic                    rd_wr;
  logic [PIX_W-1:0]        gray;
  item_ctl_t               ctl;
  logic signed [THR_W-1:0] thr;
  logic                    col_valid;
  column_t                 col;
  logic                    s2_valid;
  logic                    push_a, push_b;
  result_t                 res_a, res_b;
  logic                    out_xfer;
  result_t                 out_res;
  logic [FIFO_CW-1:0]      fifo_cnt;
  logic [FIFO_CW:0]        fifo_need;

  // An accepted item pushes up to two results two stages later. Each item
  // still in flight reserves two queue slots, so the queue never overflows
  // and the pipeline itself never stalls.
  assign fifo_need = (FIFO_CW+1)'(fifo_cnt)
                   + (FIFO_CW+1)'({col_valid, 1'b0})
                   + (FIFO_CW+1)'({s2_valid, 1'b0})
                   + (FIFO_CW+1)'(2);
  assign s_axis_tready = (fifo_need <= (FIFO_CW+1)'(FIFO_DEPTH));
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Stage zero: counters, register file, address decode and gray conversion.
  glet_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (in_xfer),
    .kind_i      (s_axis_tuser),
    .red_i       (s_axis_tdata[7:0]),
    .green_i     (s_axis_tdata[15:8]),
    .blue_i      (s_axis_tdata[23:16]),
    .addr_o      (rd_addr),
    .wr_o        (rd_wr),
    .gray_o      (gray),
    .ctl_o       (ctl),
    .thr_o       (thr)
  );

  // Stage one: the two line stores are read at the column address and, for a
  // pixel, written back in the next cycle, with a bypass for a same-entry hit.
  glet_line_mem u_line_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_en_i     (in_xfer),
    .addr_i      (rd_addr),
    .wr_i        (rd_wr),
    .gray_i      (gray),
    .col_valid_o (col_valid),
    .col_o       (col)
  );

  // Stage two: the 3x3 window shifts in the new column and both candidate
  // results are evaluated against the threshold.
  glet_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_xfer),
    .ctl_i       (ctl),
    .col_valid_i (col_valid),
    .col_i       (col),
    .thr_i       (thr),
    .s2_valid_o  (s2_valid),
    .push_a_o    (push_a),
    .res_a_o     (res_a),
    .push_b_o    (push_b),
    .res_b_o     (res_b)
  );

  assign out_xfer = m_axis_tvalid && m_axis_tready;

  glet_out_fifo u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_a_i (push_a),
    .res_a_i  (res_a),
    .push_b_i (push_b),
    .res_b_i  (res_b),
    .pop_i    (out_xfer),
    .valid_o  (m_axis_tvalid),
    .data_o   (out_res),
    .count_o  (fifo_cnt)
  );

  assign m_axis_tdata = {7'd0, out_res.edge_res};
  assign m_axis_tuser = {out_res.frame_end, out_res.row_end};
  assign m_axis_tlast = out_res.last_in_run;

endmodule

// File: design/glet_checker.sv
module glet_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  // A stalled result stays offered with the same contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // The frame's last pixel is always the last pixel of a row.
  a_frame_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
    else $error("frame end without row end");

  // A row end is always the last result of its input transfer.
  a_row_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
    else $error("row end not marked last of run");

  // An empty queue only fills through an earlier accepted input transfer.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 3))
    else $error("result without a matching input transfer");

endmodule

bind grayscale_laplacian_edge_threshold glet_checker u_glet_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
